@@ hw/rtl/v3n_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3n_pkg
// Shared types and constants of the 3D vector normalization core.
// ----------------------------------------------------------------------------
package v3n_pkg;

  // Number of root bits produced by the square root chain.
  localparam int unsigned RootBits = 24;
  // Number of quotient bits produced by the divide chain.
  localparam int unsigned QuoBits = 16;
  // Width of the scaled numerator, magnitude shifted left by 22.
  localparam int unsigned NumBits = 38;
  // 1.0 with 14 fraction bits.
  localparam logic [15:0] UnitOne = 16'd16384;

  // Input word.
  typedef struct packed {
    logic signed [15:0] x_component;
    logic signed [15:0] y_component;
    logic signed [15:0] z_component;
  } v3n_in_t;

  // Result word.
  typedef struct packed {
    logic signed [15:0] unit_x;
    logic signed [15:0] unit_y;
    logic signed [15:0] unit_z;
    logic               zero_length;
  } v3n_out_t;

  // Per-vector data that rides along the whole pipeline.
  typedef struct packed {
    logic             zero;
    logic [2:0]       neg;
    logic [2:0][15:0] mag;
  } v3n_side_t;

  // Square root cell stage.
  typedef struct packed {
    logic                valid;
    v3n_side_t           side;
    logic [31:0]         rad;
    logic [25:0]         rem;
    logic [RootBits-1:0] root;
  } v3n_sq_t;

  // Divide cell stage, three lanes sharing one divisor.
  typedef struct packed {
    logic                     valid;
    v3n_side_t                side;
    logic [RootBits-1:0]      len;
    logic [2:0][NumBits-1:0]  rem;
    logic [2:0][QuoBits-1:0]  quo;
  } v3n_dv_t;

endpackage

@@ hw/rtl/vector3_normalize_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_normalize_core
// Normalizes one signed 3D vector per cycle to a unit vector in Q1.14.
// ----------------------------------------------------------------------------
// The core takes a new word in every cycle and busy stays low. Each result
// appears on result with done high after these registered steps: squares of
// the components, their sum, a chain of 24 square root cells that settles one
// root bit each, a chain of 16 divide cells that settles one quotient bit of
// all three components each, and the output register with sign and saturation.
// The receiver must take each word in the cycle it is shown.
module vector3_normalize_core
  import v3n_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  v3n_in_t  data_in,
  output logic     busy,
  output logic     done,
  output v3n_out_t result
);

  localparam int unsigned Latency = RootBits + QuoBits + 3;

  logic               v0;
  v3n_side_t          side0;
  logic [2:0][30:0]   sq0;
  v3n_side_t          side_in;
  logic [31:0]        sum_next;
  v3n_sq_t            sq_seed;
  v3n_sq_t            sq_chain [RootBits+1];
  v3n_dv_t            dv_chain [QuoBits+1];
  v3n_dv_t            last;
  v3n_out_t           result_next;
  logic [15:0]        mag_q;

  // The pipeline never stalls.
  assign busy = 1'b0;

  // Split the components into sign and magnitude.
  always_comb begin
    side_in.zero   = 1'b0;
    side_in.neg[0] = data_in.x_component[15];
    side_in.neg[1] = data_in.y_component[15];
    side_in.neg[2] = data_in.z_component[15];
    side_in.mag[0] = data_in.x_component[15] ? 16'(-data_in.x_component)
                                             : data_in.x_component;
    side_in.mag[1] = data_in.y_component[15] ? 16'(-data_in.y_component)
                                             : data_in.y_component;
    side_in.mag[2] = data_in.z_component[15] ? 16'(-data_in.z_component)
                                             : data_in.z_component;
  end

  // Square each magnitude.
  always_ff @(posedge clk) begin
    side0 <= side_in;
    for (int i = 0; i < 3; i++) begin
      sq0[i] <= 31'(side_in.mag[i] * side_in.mag[i]);
    end
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start;
    end
  end

  // Sum the squares and seed the square root chain.
  assign sum_next = 32'(sq0[0]) + 32'(sq0[1]) + 32'(sq0[2]);

  always_comb begin
    sq_seed           = '0;
    sq_seed.valid     = rst ? 1'b0 : v0;
    sq_seed.side      = side0;
    sq_seed.side.zero = sum_next == 32'd0;
    sq_seed.rad       = sum_next;
  end

  always_ff @(posedge clk) begin
    sq_chain[0] <= sq_seed;
  end

  // Square root chain, most significant root bit first.
  for (genvar g = 0; g < RootBits; g++) begin : g_sqrt
    v3n_sqrt_cell u_cell (
      .clk (clk),
      .rst (rst),
      .d   (sq_chain[g]),
      .q   (sq_chain[g+1])
    );
  end

  // Seed the divide chain with the scaled magnitudes.
  always_comb begin
    dv_chain[0].valid = sq_chain[RootBits].valid;
    dv_chain[0].side  = sq_chain[RootBits].side;
    dv_chain[0].len   = sq_chain[RootBits].root;
    for (int i = 0; i < 3; i++) begin
      dv_chain[0].rem[i] = {sq_chain[RootBits].side.mag[i], 22'd0};
      dv_chain[0].quo[i] = '0;
    end
  end

  // Divide chain, most significant quotient bit first.
  for (genvar g = 0; g < QuoBits; g++) begin : g_div
    v3n_div_cell #(
      .STEP (QuoBits - 1 - g)
    ) u_cell (
      .clk (clk),
      .rst (rst),
      .d   (dv_chain[g]),
      .q   (dv_chain[g+1])
    );
  end

  assign last = dv_chain[QuoBits];

  // Saturate, apply the sign and force zeros for a zero vector.
  always_comb begin
    logic [15:0] lane [3];
    for (int i = 0; i < 3; i++) begin
      mag_q = last.quo[i];
      if (({2'b00, last.side.mag[i], 6'd0} >= last.len) || (mag_q > UnitOne)) begin
        mag_q = UnitOne;
      end
      if (last.side.zero) begin
        lane[i] = '0;
      end else begin
        lane[i] = last.side.neg[i] ? 16'(-mag_q) : mag_q;
      end
    end
    result_next.unit_x      = lane[0];
    result_next.unit_y      = lane[1];
    result_next.unit_z      = lane[2];
    result_next.zero_length = last.side.zero;
  end

  // Output register.
  always_ff @(posedge clk) begin
    result <= result_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= last.valid;
    end
  end

`ifndef SYNTHESIS
  // A word leaves exactly one pipeline length after it entered.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, Latency))
    else $error("done without a matching start");

  // A zero vector gives an all-zero unit vector.
  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    done && result.zero_length |->
      result.unit_x == 16'sd0 && result.unit_y == 16'sd0 && result.unit_z == 16'sd0)
    else $error("zero vector gave nonzero output");

  // Unit components stay within plus or minus one.
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> result.unit_x <= 16'sd16384 && result.unit_x >= -16'sd16384 &&
             result.unit_y <= 16'sd16384 && result.unit_y >= -16'sd16384 &&
             result.unit_z <= 16'sd16384 && result.unit_z >= -16'sd16384)
    else $error("unit component out of range");

  // The divisor at the end of the chain is nonzero for a nonzero vector.
  a_len: assert property (@(posedge clk) disable iff (rst)
    last.valid && !last.side.zero |-> last.len != '0)
    else $error("zero length for nonzero vector");
`endif

endmodule

@@ hw/rtl/v3n_sqrt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3n_sqrt_cell
// One digit of the bit-serial integer square root: takes two radicand bits
// and settles one root bit, then hands the partial result to the next cell.
// ----------------------------------------------------------------------------
module v3n_sqrt_cell
  import v3n_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  v3n_sq_t d,
  output v3n_sq_t q
);

  logic [26:0] shifted;
  logic [26:0] trial;
  logic        fits;
  v3n_sq_t     q_next;

  // Bring in the next two radicand bits and try the candidate root bit.
  always_comb begin
    shifted = {d.rem[24:0], d.rad[31:30]};
    trial   = {1'b0, d.root, 2'b01};
    fits    = shifted >= trial;
    q_next       = d;
    q_next.valid = rst ? 1'b0 : d.valid;
    q_next.rad   = {d.rad[29:0], 2'b00};
    if (fits) begin
      q_next.rem  = 26'(shifted - trial);
      q_next.root = {d.root[RootBits-2:0], 1'b1};
    end else begin
      q_next.rem  = shifted[25:0];
      q_next.root = {d.root[RootBits-2:0], 1'b0};
    end
  end

  // Stage register; only the valid flag is reset.
  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

@@ hw/rtl/v3n_div_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3n_div_cell
// One restoring division step for three lanes that share a divisor: settles
// quotient bit STEP of each lane and passes the remainders on.
// ----------------------------------------------------------------------------
module v3n_div_cell
  import v3n_pkg::*;
#(
  parameter int unsigned STEP = 0
) (
  input  logic    clk,
  input  logic    rst,
  input  v3n_dv_t d,
  output v3n_dv_t q
);

  logic [NumBits+1:0] dvs;
  v3n_dv_t            q_next;

  // Compare each remainder with the shifted divisor and subtract on a fit.
  always_comb begin
    dvs          = (NumBits + 2)'(d.len) << STEP;
    q_next       = d;
    q_next.valid = rst ? 1'b0 : d.valid;
    for (int i = 0; i < 3; i++) begin
      if ({2'b00, d.rem[i]} >= dvs) begin
        q_next.rem[i] = NumBits'(d.rem[i] - dvs[NumBits-1:0]);
        q_next.quo[i] = d.quo[i] | (QuoBits'(1) << STEP);
      end
    end
  end

  // Stage register; only the valid flag is reset.
  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the 3D vector normalization core against a cycle-free predictor:
// directed corner vectors, then random bursts, every result compared in order.
// ----------------------------------------------------------------------------
module tb;
  import v3n_pkg::*;

  logic     clk;
  logic     rst;
  logic     start;
  v3n_in_t  data_in;
  logic     busy;
  logic     done;
  v3n_out_t result;

  v3n_out_t unit_queue[$];
  int       error_count;

  vector3_normalize_core DUT (
    .clk(clk), .rst(rst), .start(start), .data_in(data_in),
    .busy(busy), .done(done), .result(result)
  );

  // Clock, 10 ns period.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Floor square root, one result bit at a time.
  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned rem_v;
    longint unsigned root_v;
    longint unsigned bit_v;
    rem_v = n;
    root_v = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > rem_v) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (rem_v >= root_v + bit_v) begin
        rem_v = rem_v - (root_v + bit_v);
        root_v = (root_v >> 1) + bit_v;
      end else begin
        root_v = root_v >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return root_v;
  endfunction

  // One component divided by the length, saturated to 1.0 in magnitude.
  function automatic logic signed [15:0] scale_component(logic signed [15:0] c,
                                                         longint unsigned len);
    longint          cv;
    longint unsigned mag;
    longint unsigned q;
    cv = c;
    mag = (cv < 0) ? -cv : cv;
    q = (mag << 22) / len;
    if (q > UnitOne) q = UnitOne;
    if (cv < 0) q = -q;
    return q[15:0];
  endfunction

  function automatic v3n_out_t normalize(v3n_in_t v);
    v3n_out_t        o;
    longint          x;
    longint          y;
    longint          z;
    longint unsigned s;
    longint unsigned len;
    x = v.x_component;
    y = v.y_component;
    z = v.z_component;
    s = x * x + y * y + z * z;
    o = '0;
    if (s == 0) begin
      o.zero_length = 1'b1;
    end else begin
      len = floor_sqrt(s << 16);
      o.unit_x = scale_component(v.x_component, len);
      o.unit_y = scale_component(v.y_component, len);
      o.unit_z = scale_component(v.z_component, len);
    end
    return o;
  endfunction

  task automatic report(string what);
    error_count++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  // Send one word and record its expected result once it is accepted.
  task automatic send_vector(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    v3n_in_t v;
    v.x_component = x;
    v.y_component = y;
    v.z_component = z;
    start <= 1'b1;
    data_in <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    unit_queue.push_back(normalize(v));
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Check every result word against the oldest expectation.
  always @(posedge clk) begin
    v3n_out_t want;
    if (!rst && done) begin
      if (unit_queue.size() == 0) begin
        report("result word with nothing expected");
      end else begin
        want = unit_queue.pop_front();
        if (result.unit_x !== want.unit_x)
          report($sformatf("unit_x %0d expected %0d", result.unit_x, want.unit_x));
        if (result.unit_y !== want.unit_y)
          report($sformatf("unit_y %0d expected %0d", result.unit_y, want.unit_y));
        if (result.unit_z !== want.unit_z)
          report($sformatf("unit_z %0d expected %0d", result.unit_z, want.unit_z));
        if (result.zero_length !== want.zero_length)
          report($sformatf("zero_length %0b expected %0b", result.zero_length,
                           want.zero_length));
      end
    end
  end

  // Corner vectors: zero, extremes, single axes and overshoot cases.
  task automatic test_directed();
    send_vector(16'h0000, 16'h0000, 16'h0000);
    send_vector(16'h7fff, 16'h7fff, 16'h7fff);
    send_vector(16'h8000, 16'h8000, 16'h8000);
    send_vector(16'h8000, 16'h0000, 16'h0000);
    send_vector(16'h0000, 16'h7fff, 16'h0000);
    send_vector(16'h0000, 16'h0000, 16'h8000);
    send_vector(16'h0001, 16'h0000, 16'h0000);
    send_vector(16'hffff, 16'h0000, 16'h0000);
    send_vector(16'h0001, 16'h0001, 16'h0001);
    send_vector(16'hffff, 16'h0001, 16'hffff);
    send_vector(16'h7fff, 16'h8000, 16'h0001);
    send_vector(16'h0003, 16'h0004, 16'h0000);
    send_vector(16'h0100, 16'h0000, 16'h0000);
    send_vector(16'h0000, 16'h0000, 16'h0000);
    send_vector(16'h5555, 16'haaaa, 16'h1234);
    idle_cycles(3);
  endtask

  // Send one more word, then pause until every pending result has come out.
  task automatic test_drain();
    send_vector(16'h0000, 16'hff00, 16'h0000);
    start <= 1'b0;
    while (unit_queue.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] random_component();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 3) - 1);
      1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      2: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  // Random vectors in bursts with random gaps, some bursts back to back.
  task automatic test_random(int total);
    int sent;
    int burst;
    sent = 0;
    while (sent < total) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        if ($urandom_range(0, 30) == 0)
          send_vector(16'h0000, 16'h0000, 16'h0000);
        else
          send_vector(random_component(), random_component(), random_component());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 12));
    end
    start <= 1'b0;
  endtask

  initial begin
    error_count = 0;
    rst = 1'b1;
    start = 1'b0;
    data_in = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_drain();
    test_random(1400);
    while (unit_queue.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
